FILE: rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cursor engine
// Holds the item structs, the opcode and state encodings and the fixed
// character and cell constants of the console.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // Default screen geometry.
  localparam int DefaultColumns = 80;
  localparam int DefaultRows    = 25;

  // Field widths of the items.
  localparam int OpcodeW  = 2;
  localparam int CharW    = 8;
  localparam int RowFldW  = 5;
  localparam int ColFldW  = 7;
  localparam int CellW    = 16;
  localparam int AttrW    = 8;

  // Configuration port.
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;
  localparam logic [PaddrW-3:0] RegTextAttribute = '0;

  // Cell and character constants.
  localparam logic [CellW-1:0] BlankCell     = 16'h0F20;
  localparam logic [AttrW-1:0] AttrReset     = 8'h0F;
  localparam logic [CharW-1:0] CharNewline   = 8'd10;
  localparam logic [CharW-1:0] CharBackspace = 8'd8;

  typedef enum logic [OpcodeW-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } tcce_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK,
    ST_FINISH
  } tcce_state_e;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [CharW-1:0]   char_code;
    logic [RowFldW-1:0] read_row;
    logic [ColFldW-1:0] read_col;
  } tcce_in_t;

  typedef struct packed {
    logic [RowFldW-1:0] cursor_row_out;
    logic [ColFldW-1:0] cursor_col_out;
    logic [CellW-1:0]   cell_value;
    logic               scrolled;
  } tcce_out_t;

endpackage : tcce_pkg

`default_nettype wire

FILE: rtl/text_console_cursor_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit: text console cell store with a cursor
// Keeps a COLUMNS x ROWS store of 16-bit character cells in one synchronous
// memory, handles put, read and clear items and scrolls the screen.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that blanks every cell to 0x0F20;
// in_ready_o stays low until it ends, while configuration writes are taken
// throughout. One item is handled at a time. A put, a read or an unused opcode
// passes through the idle state in which it is accepted, an execute state for
// the access to the cell memory and a finish state that loads the output
// register, waiting there while an earlier result is still untaken in it.
// A put that scrolls goes from the execute state through a scroll sweep, in
// which the one read and one write port of the cell memory copy the screen up
// one cell a cycle, a drain state and a blank sweep of the bottom row; a clear
// blanks the whole store in a blank sweep. The next item is accepted while a
// finished result still waits in the output register. The attribute register
// lies at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_unit #(
  parameter int COLUMNS = tcce_pkg::DefaultColumns,
  parameter int ROWS    = tcce_pkg::DefaultRows
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire tcce_pkg::tcce_in_t          in_item_i,

  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      tcce_pkg::tcce_out_t         out_item_o,

  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcce_pkg::PaddrW-1:0] paddr,
  input  wire logic [tcce_pkg::PdataW-1:0] pwdata,
  output      logic [tcce_pkg::PdataW-1:0] prdata,
  output      logic                        pready
);

  import tcce_pkg::*;

  // Geometry derived from the parameters. The linear cursor address can
  // briefly reach Cells (one past the last cell) before a scroll pulls it back.
  localparam int Cells = COLUMNS * ROWS;
  localparam int MemAW = $clog2(Cells);
  localparam int AW    = $clog2(Cells + 1);
  localparam int RowW  = $clog2(ROWS + 1);
  localparam int ColW  = $clog2(COLUMNS + 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [AttrW-1:0] attr_q;
  logic             cfg_sel;

  assign cfg_sel = (paddr[PaddrW-1:2] == RegTextAttribute);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? PdataW'(attr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= AttrReset;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      attr_q <= pwdata[AttrW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and cursor state
  // ---------------------------------------------------------------------------
  tcce_state_e       state_q, state_d;
  tcce_in_t          item_q, item_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [AW-1:0]     addr_q, addr_d;     // linear cell address of the cursor
  logic [AW-1:0]     scan_q, scan_d;     // sweep address for copy and blank
  logic              cp_valid_q, cp_valid_d;
  logic [MemAW-1:0]  cp_addr_q, cp_addr_d;
  logic              scrolled_q, scrolled_d;
  logic              cell_en_q, cell_en_d;
  logic              out_valid_q, out_valid_d;
  tcce_out_t         out_q, out_d;

  // Memory port signals.
  logic              mem_we;
  logic [MemAW-1:0]  mem_waddr;
  logic [CellW-1:0]  mem_wdata;
  logic              mem_re;
  logic [MemAW-1:0]  mem_raddr;
  logic [CellW-1:0]  rd_q;

  // Scroll, sweep-end, output-space and read-range decoding.
  logic              scroll_c;
  logic              sweep_end;
  logic              out_free;
  logic              rd_in_range;
  logic [AW-1:0]     rd_lin;

  assign sweep_end   = (scan_q == AW'(Cells - 1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign rd_in_range = (32'(item_q.read_row) < ROWS) && (32'(item_q.read_col) < COLUMNS);
  assign rd_lin      = AW'(item_q.read_row) * AW'(COLUMNS) + AW'(item_q.read_col);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (item_q.opcode)
          OP_PUT:   state_d = scroll_c ? ST_SCROLL : ST_FINISH;
          OP_CLEAR: state_d = ST_BLANK;
          default:  state_d = ST_FINISH;
        endcase
      end
      ST_SCROLL: begin
        if (sweep_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (sweep_end) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [RowW-1:0] row_c;
    logic [ColW-1:0] col_c;
    logic [AW-1:0]   addr_c;

    item_d      = item_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    scan_d      = scan_q;
    cp_valid_d  = 1'b0;
    cp_addr_d   = cp_addr_q;
    scrolled_d  = scrolled_q;
    cell_en_d   = cell_en_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    scroll_c    = 1'b0;

    mem_we      = 1'b0;
    mem_waddr   = scan_q[MemAW-1:0];
    mem_wdata   = BlankCell;
    mem_re      = 1'b0;
    mem_raddr   = scan_q[MemAW-1:0];

    row_c       = row_q;
    col_c       = col_q;
    addr_c      = addr_q;

    // A copy read in the previous cycle lands one row higher.
    if (cp_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = cp_addr_q;
      mem_wdata = rd_q;
    end

    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        scan_d = scan_q + AW'(1);
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          item_d     = in_item_i;
          scrolled_d = 1'b0;
          cell_en_d  = 1'b0;
        end
      end

      ST_EXEC: begin
        unique case (item_q.opcode)
          OP_PUT: begin
            if (item_q.char_code == CharNewline) begin
              col_c  = '0;
              row_c  = row_q + RowW'(1);
              addr_c = addr_q - AW'(col_q) + AW'(COLUMNS);
            end else if (item_q.char_code == CharBackspace) begin
              // Steps back across the row start, but never before home.
              if (col_q != '0) begin
                col_c  = col_q - ColW'(1);
                addr_c = addr_q - AW'(1);
              end else if (row_q != '0) begin
                row_c  = row_q - RowW'(1);
                col_c  = ColW'(COLUMNS - 1);
                addr_c = addr_q - AW'(1);
              end
              mem_we    = 1'b1;
              mem_waddr = addr_c[MemAW-1:0];
              mem_wdata = BlankCell;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = addr_q[MemAW-1:0];
              mem_wdata = {attr_q, item_q.char_code};
              col_c     = col_q + ColW'(1);
              addr_c    = addr_q + AW'(1);
              if (col_c == ColW'(COLUMNS)) begin
                col_c = '0;
                row_c = row_q + RowW'(1);
              end
            end
            // Falling off the bottom row scrolls the screen up by one row.
            if (row_c == RowW'(ROWS)) begin
              scroll_c = 1'b1;
              row_c    = RowW'(ROWS - 1);
              addr_c   = addr_c - AW'(COLUMNS);
              scan_d   = AW'(COLUMNS);
            end
            row_d      = row_c;
            col_d      = col_c;
            addr_d     = addr_c;
            scrolled_d = scroll_c;
          end
          OP_READ: begin
            cell_en_d = rd_in_range;
            mem_re    = rd_in_range;
            mem_raddr = rd_lin[MemAW-1:0];
          end
          OP_CLEAR: begin
            row_d  = '0;
            col_d  = '0;
            addr_d = '0;
            scan_d = '0;
          end
          default: ;
        endcase
      end

      ST_SCROLL: begin
        // Read one cell a cycle; it is written back COLUMNS cells lower.
        mem_re     = 1'b1;
        mem_raddr  = scan_q[MemAW-1:0];
        cp_valid_d = 1'b1;
        cp_addr_d  = MemAW'(scan_q - AW'(COLUMNS));
        scan_d     = sweep_end ? AW'(Cells - COLUMNS) : scan_q + AW'(1);
      end

      ST_DRAIN: ;

      ST_BLANK: begin
        mem_we = 1'b1;
        scan_d = scan_q + AW'(1);
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.cursor_row_out = RowFldW'(row_q);
          out_d.cursor_col_out = ColFldW'(col_q);
          out_d.cell_value     = cell_en_q ? rd_q : '0;
          out_d.scrolled       = scrolled_q;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      scan_q      <= '0;
      cp_valid_q  <= 1'b0;
      scrolled_q  <= 1'b0;
      cell_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      addr_q      <= addr_d;
      scan_q      <= scan_d;
      cp_valid_q  <= cp_valid_d;
      scrolled_q  <= scrolled_d;
      cell_en_q   <= cell_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    cp_addr_q <= cp_addr_d;
    out_q     <= out_d;
  end

  // ---------------------------------------------------------------------------
  // Cell memory: one write port, one read port with registered data.
  // ---------------------------------------------------------------------------
  logic [CellW-1:0] cell_mem [Cells];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= cell_mem[mem_raddr];
    end
  end

endmodule : text_console_cursor_engine_unit

`default_nettype wire

FILE: test/text_console_cursor_engine_checker.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_checker: result checker of the console engine
// Watches the item channels and the APB port, keeps its own copy of the cell
// store, cursor and attribute, and compares every result with its prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire tcce_pkg::tcce_in_t          in_item_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire tcce_pkg::tcce_out_t         out_item_i,
  input  wire logic                        psel_i,
  input  wire logic                        penable_i,
  input  wire logic                        pwrite_i,
  input  wire logic [tcce_pkg::PaddrW-1:0] paddr_i,
  input  wire logic [tcce_pkg::PdataW-1:0] pwdata_i,
  input  wire logic                        pready_i,
  output      int                          mismatch_count_o,
  output      int                          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int NumCols    = DefaultColumns;
  localparam int NumRows    = DefaultRows;
  localparam int CellCount  = NumCols * NumRows;
  localparam int MaxReports = 10;
  localparam logic [PaddrW-1:0] AttrAddr = {RegTextAttribute, 2'b00};

  logic [CellW-1:0] screen [CellCount];
  int unsigned      cur_row;
  int unsigned      cur_col;
  logic [AttrW-1:0] attribute;
  tcce_out_t        expected_results [$];
  int               mismatches;

  // Applies one item to the shadow console and returns the result it gives.
  function automatic tcce_out_t apply_console_op(tcce_in_t item);
    tcce_out_t res;
    res = '0;
    case (item.opcode)
      OP_PUT: begin
        if (item.char_code == CharNewline) begin
          cur_col = 0;
          cur_row++;
        end else if (item.char_code == CharBackspace) begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = NumCols - 1;
          end
          screen[cur_row * NumCols + cur_col] = BlankCell;
        end else begin
          screen[cur_row * NumCols + cur_col] = {attribute, item.char_code};
          cur_col++;
        end
        if (cur_col >= NumCols) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= NumRows) begin
          for (int i = 0; i < CellCount - NumCols; i++) begin
            screen[i] = screen[i + NumCols];
          end
          for (int i = CellCount - NumCols; i < CellCount; i++) begin
            screen[i] = BlankCell;
          end
          cur_row = NumRows - 1;
          res.scrolled = 1'b1;
        end
      end
      OP_READ: begin
        if (item.read_row < NumRows && item.read_col < NumCols) begin
          res.cell_value = screen[item.read_row * NumCols + item.read_col];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CellCount; i++) begin
          screen[i] = BlankCell;
        end
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    res.cursor_row_out = RowFldW'(cur_row);
    res.cursor_col_out = ColFldW'(cur_col);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tcce_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CellCount; i++) begin
        screen[i] = BlankCell;
      end
      cur_row = 0;
      cur_col = 0;
      attribute = AttrReset;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == AttrAddr) begin
        attribute = pwdata_i[AttrW-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("checker: result with none expected: row %0d col %0d cell %h scr %b",
                     out_item_i.cursor_row_out, out_item_i.cursor_col_out,
                     out_item_i.cell_value, out_item_i.scrolled);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.cursor_row_out !== want.cursor_row_out ||
              out_item_i.cursor_col_out !== want.cursor_col_out ||
              out_item_i.cell_value     !== want.cell_value ||
              out_item_i.scrolled       !== want.scrolled) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display({"checker: mismatch: expected row %0d col %0d cell %h scr %b,",
                        " got row %0d col %0d cell %h scr %b"},
                       want.cursor_row_out, want.cursor_col_out, want.cell_value,
                       want.scrolled, out_item_i.cursor_row_out,
                       out_item_i.cursor_col_out, out_item_i.cell_value,
                       out_item_i.scrolled);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_console_op(in_item_i));
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= expected_results.size();
  end

endmodule : text_console_cursor_engine_checker

`default_nettype wire

FILE: test/text_console_cursor_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit_tb: testbench of the text console engine
// Drives put, read, clear and unused items into the engine under random
// handshake gaps and attribute settings; a separate checker predicts every
// result and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  // The opcode left unused by the engine; it must be a no-operation.
  localparam logic [OpcodeW-1:0] OpUnused = 2'd3;

  // Register addresses: the attribute register and the first address past it.
  localparam logic [PaddrW-1:0] AttrAddr     = {RegTextAttribute, 2'b00};
  localparam logic [PaddrW-1:0] SpareRegAddr = 3'd4;

  localparam int NumCols      = DefaultColumns;
  localparam int NumRows      = DefaultRows;
  localparam int NumPhases    = 5;
  localparam int PhaseItems   = 290;
  localparam int HoldOffCycles = 300;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;

  logic      in_valid  = 1'b0;
  logic      in_ready;
  tcce_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tcce_out_t out_item;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PaddrW-1:0]   paddr   = '0;
  logic [PdataW-1:0]   pwdata  = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  int mismatch_count;
  int pending_count;

  // Set by the stimulus: quiet_phase turns off all random gaps on both sides,
  // hold_off_pending asks the receiver for one long stall.
  bit quiet_phase      = 1'b0;
  bit hold_off_pending = 1'b0;

  // Clock with a 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  text_console_cursor_engine_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  text_console_cursor_engine_checker result_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // Each side takes a gap with a chance of roughly 31 in a hundred, except in the
  // quiet phase, where neither side ever idles.
  function automatic bit take_gap();
    return !quiet_phase && ($urandom_range(99) < 31);
  endfunction

  function automatic tcce_in_t make_item(input logic [OpcodeW-1:0] op,
                                         input logic [CharW-1:0]   ch,
                                         input logic [RowFldW-1:0] row,
                                         input logic [ColFldW-1:0] col);
    tcce_in_t item;
    item.opcode    = op;
    item.char_code = ch;
    item.read_row  = row;
    item.read_col  = col;
    return item;
  endfunction

  // Offers one item and returns in the time step in which it was taken. Valid
  // is only lowered when a gap is taken, so a valid that stays high between
  // two items never sees two assignments in one step.
  task automatic send_item(input tcce_in_t item);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering items and waits until the checker holds no expectation,
  // then lets the given number of further cycles pass. The first edge is
  // always waited for, so that an item taken in the calling step is counted.
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (settle) @(posedge clk);
  endtask

  // One APB write: a setup phase, then an access phase that completes at the
  // edge where pready is seen high; psel then drops and stays low until the next write.
  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request while the
  // sender keeps offering items, so that the output register fills and the
  // engine has to stall its input.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        out_ready <= 1'b0;
        hold_off_pending = 1'b0;
        repeat (HoldOffCycles - 1) @(posedge clk);
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  initial begin : stimulus
    tcce_in_t    item;
    int          roll;
    logic [AttrW-1:0] attr_value;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items with the reset attribute. The engine first runs its
    // clearing pass, so the first item simply waits for in_ready.
    send_item(make_item(OP_READ, 8'h00, 5'd0, 7'd0));       // blank after reset
    send_item(make_item(OP_PUT, CharBackspace, 5'd0, 7'd0)); // backspace at home
    send_item(make_item(OP_PUT, 8'h41, 5'd0, 7'd0));
    send_item(make_item(OP_PUT, 8'h00, 5'd0, 7'd0));
    send_item(make_item(OP_PUT, 8'hFF, 5'd31, 7'd127));     // top byte stays unsigned
    send_item(make_item(OP_READ, 8'hFF, 5'd0, 7'd2));
    send_item(make_item(OP_READ, 8'h00, 5'd31, 7'd127));    // both coordinates out of range
    send_item(make_item(OP_READ, 8'h00, 5'd25, 7'd0));      // first row past the screen
    send_item(make_item(OP_READ, 8'h00, 5'd0, 7'd80));      // first column past the screen
    send_item(make_item(OpUnused, 8'($urandom_range(255)), 5'($urandom_range(31)),
                        7'($urandom_range(127))));
    send_item(make_item(OP_PUT, CharNewline, 5'd0, 7'd0));

    // A bright attribute, and a write to the spare address that must change
    // nothing. Backspace must still blank with the fixed blank cell.
    drain_results(4);
    apb_write(AttrAddr, 32'h0000_00FF);
    apb_write(SpareRegAddr, '1);
    send_item(make_item(OP_PUT, 8'h7E, 5'd0, 7'd0));
    send_item(make_item(OP_PUT, CharBackspace, 5'd0, 7'd0));
    send_item(make_item(OP_READ, 8'h00, 5'd1, 7'd0));
    send_item(make_item(OP_PUT, CharBackspace, 5'd0, 7'd0)); // wraps to end of row 0
    send_item(make_item(OP_READ, 8'h00, 5'd0, 7'd79));
    send_item(make_item(OP_READ, 8'h00, 5'(NumRows - 1), 7'(NumCols - 1)));
    send_item(make_item(OP_CLEAR, 8'h00, 5'd0, 7'd0));
    send_item(make_item(OP_READ, 8'h00, 5'd0, 7'd2));

    // Random phases, each under its own attribute: the two extremes first,
    // then random values. Phase 1 carries the long receiver hold-off, phase 2
    // runs with no gaps at all, and in phase 3 the sender pauses until every
    // result is back.
    for (int p = 0; p < NumPhases; p++) begin
      drain_results(4);
      case (p)
        0:       attr_value = 8'h00;
        1:       attr_value = 8'hFF;
        default: attr_value = 8'($urandom_range(255));
      endcase
      apb_write(AttrAddr, {24'($urandom), attr_value});
      quiet_phase = (p == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 1 && n == 100) begin
          hold_off_pending = 1'b1;
        end
        if (p == 3 && n == 150) begin
          drain_results(0);
        end
        // Fields that an opcode ignores are left random as noise. Most items
        // are text with line breaks and rubs out, so that the cursor wraps and
        // the screen scrolls often; clears stay rare as they are slow.
        item = tcce_in_t'($urandom);
        roll = $urandom_range(99);
        if (roll < 62) begin
          item.opcode = OP_PUT;
        end else if (roll < 70) begin
          item.opcode    = OP_PUT;
          item.char_code = CharNewline;
        end else if (roll < 77) begin
          item.opcode    = OP_PUT;
          item.char_code = CharBackspace;
        end else if (roll < 94) begin
          item.opcode = OP_READ;
          if ($urandom_range(4) != 0) begin
            item.read_row = 5'($urandom_range(NumRows - 1));
            item.read_col = 7'($urandom_range(NumCols - 1));
          end
        end else if (roll < 98) begin
          item.opcode = OpUnused;
        end else begin
          item.opcode = OP_CLEAR;
        end
        send_item(item);
      end
    end
    quiet_phase = 1'b0;

    // All items are in; wait for the last results and a short tail in which
    // any stray result would still show up in the checker.
    drain_results(20);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit. The slowest correct run has every item scroll on top of the gaps
  // and one long hold-off: roughly 6.2 ms. The limit allows several times that.
  initial begin : run_limit
    #30ms;
    $display("tb: failure");
    $finish;
  end

endmodule : text_console_cursor_engine_unit_tb

`default_nettype wire
